// ===== rtl/pbre_pkg.sv =====
package pbre_pkg;

  localparam int SampleWidth = 24;
  localparam int CoefWidth = 32;
  localparam int CoefFrac = CoefWidth - 4;
  localparam int InShift = 39 - SampleWidth;
  localparam int StWidth = 48;
  localparam int TanhEntries = 256;
  localparam int TanhIdxW = 8;
  localparam int HarmWidth = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegB0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegB1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegB2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegA1 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegA2 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBypass = 3'd5;
  localparam logic [CfgIdxW-1:0] RegExcEn = 3'd6;
  localparam logic [CfgIdxW-1:0] RegHarm = 3'd7;

  localparam logic signed [StWidth-1:0] StMax = {1'b0, {(StWidth-1){1'b1}}};
  localparam logic signed [StWidth-1:0] StMin = {1'b1, {(StWidth-1){1'b0}}};

  // Request handed to the serial multiplier: a start strobe and two signed operands.
  typedef struct packed {
    logic start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } mul_req_t;

  function automatic logic signed [StWidth-1:0] sat48(input logic signed [63:0] v);
    logic signed [StWidth-1:0] r;
    if (v > 64'(StMax)) r = StMax;
    else if (v < 64'(StMin)) r = StMin;
    else r = v[StWidth-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/pbre_sermul.sv =====
// Signed 64x64 multiplier, one bit of the multiplier per cycle.
module pbre_sermul (
  input  logic clk,
  input  logic rst_n,
  input  pbre_pkg::mul_req_t req,
  output logic busy,
  output logic signed [127:0] prod
);

  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [127:0] mcand_r, mcand_nxt;
  logic [63:0] mplr_r, mplr_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    acc_nxt = acc_r;
    mcand_nxt = mcand_r;
    mplr_nxt = mplr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 7'd0;
      acc_nxt = '0;
      mcand_nxt = {{64{req.a[63]}}, req.a};
      mplr_nxt = req.b;
    end else if (busy_r) begin
      // Top bit carries negative weight in two's complement.
      if (mplr_r[0]) begin
        if (cnt_r == 7'd63) acc_nxt = acc_r - mcand_r;
        else acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = mcand_r << 1;
      mplr_nxt = mplr_r >> 1;
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= 7'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mcand_r <= mcand_nxt;
    mplr_r <= mplr_nxt;
  end

  assign busy = busy_r | req.start;
  assign prod = acc_r;

endmodule

// ===== rtl/pbre_serdiv.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
module pbre_serdiv (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic busy,
  output logic [63:0] quo
);

  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [63:0] q_r, q_nxt, rem_r, rem_nxt, den_r, den_nxt;
  logic [64:0] trial;

  always_comb begin
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    trial = {rem_r, q_r[63]} - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 7'd0;
      q_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], q_r[63]};
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= 7'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r | start;
  assign quo = q_r;

endmodule

// ===== rtl/peaking_biquad_residual_exciter_unit.sv =====
// In bypass with the exciter off, an accepted word goes through S_EX and S_OUT to out_valid.
// Each product uses the bit-serial multiplier: five for the filter, up to four for
// shaping, so bypass with shaping on needs only the shaping products.
// One word at a time; the 1-bit-per-cycle multiplier sets the rate while the output is not stalled.
// After reset a sweep builds the 257-entry tanh table and the
// reciprocal with the shared serial units; no word is taken then. Reset is
// synchronous, active low, and restores the default registers.
module peaking_biquad_residual_exciter_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [pbre_pkg::SampleWidth-1:0] in_sample_in,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [pbre_pkg::SampleWidth-1:0] out_sample_out,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [pbre_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [pbre_pkg::CfgDataW-1:0] cfg_data
);

  // Sequencer states.
  localparam logic [4:0] S_Q = 5'd0;     // series for q, one term per step
  localparam logic [4:0] S_QD = 5'd1;
  localparam logic [4:0] S_E = 5'd2;     // e = e*q per table entry
  localparam logic [4:0] S_ED = 5'd3;
  localparam logic [4:0] S_TD = 5'd4;    // table division
  localparam logic [4:0] S_RD = 5'd5;    // reciprocal division
  localparam logic [4:0] S_IDLE = 5'd6;
  localparam logic [4:0] S_Y = 5'd7;
  localparam logic [4:0] S_D1A = 5'd8;
  localparam logic [4:0] S_D1B = 5'd9;
  localparam logic [4:0] S_D2A = 5'd10;
  localparam logic [4:0] S_D2B = 5'd11;
  localparam logic [4:0] S_EX = 5'd12;
  localparam logic [4:0] S_SC = 5'd13;   // two table reads at the scaled position
  localparam logic [4:0] S_IP = 5'd14;   // table interpolation
  localparam logic [4:0] S_RC = 5'd15;   // times reciprocal
  localparam logic [4:0] S_HM = 5'd16;   // blend by harmonic
  localparam logic [4:0] S_OUT = 5'd17;
  localparam logic [4:0] S_QW = 5'd18;
  localparam logic [4:0] S_EW = 5'd19;
  localparam logic [4:0] S_TW = 5'd20;
  localparam logic [4:0] S_RW = 5'd21;
  localparam logic [4:0] S_YW = 5'd22;
  localparam logic [4:0] S_D1AW = 5'd23;
  localparam logic [4:0] S_D1BW = 5'd24;
  localparam logic [4:0] S_D2AW = 5'd25;
  localparam logic [4:0] S_D2BW = 5'd26;
  localparam logic [4:0] S_SCW = 5'd27;
  localparam logic [4:0] S_IPW = 5'd28;
  localparam logic [4:0] S_RCW = 5'd29;
  localparam logic [4:0] S_HMW = 5'd30;

  localparam logic [63:0] EOne = 64'h8000_0000;
  localparam logic [63:0] ArgA = 64'((64'd16 << 31) / pbre_pkg::TanhEntries);

  logic [4:0] st_r, st_nxt;

  logic signed [pbre_pkg::CoefWidth-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic bypass_r, exc_r;
  logic [pbre_pkg::HarmWidth-1:0] harm_r;
  logic [19:0] drive_r;
  logic [63:0] recip_r, recip_nxt;
  logic recip_go_r, recip_go_nxt;

  // Table memory.
  logic [31:0] tab_mem [0:pbre_pkg::TanhEntries];
  logic tab_we;
  logic [pbre_pkg::TanhIdxW:0] tab_waddr, tab_raddr;
  logic [31:0] tab_wdata, tab_rdata_r;

  logic [pbre_pkg::TanhIdxW:0] k_r, k_nxt;
  logic [3:0] n_r, n_nxt;
  logic [63:0] term_r, term_nxt, q_r, q_nxt, e_r, e_nxt;

  logic signed [63:0] x_r, x_nxt, y_r, y_nxt, acc_r, acc_nxt, lin_r, lin_nxt;
  logic signed [63:0] r_r, r_nxt, res_r, res_nxt;
  logic signed [pbre_pkg::StWidth-1:0] d1_r, d1_nxt, d2_r, d2_nxt;
  logic neg_r, neg_nxt;
  logic [63:0] s_r, s_nxt;
  logic [31:0] t0_r, t0_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [pbre_pkg::SampleWidth-1:0] out_r, out_nxt;

  pbre_pkg::mul_req_t mreq;
  logic mbusy;
  logic signed [127:0] mprod;
  logic dstart, dbusy;
  logic [63:0] dnum, dden, dquo;

  pbre_sermul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .busy(mbusy), .prod(mprod));
  pbre_serdiv u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
                     .busy(dbusy), .quo(dquo));

  // Floor of a Q4.F coefficient product, exact over 128 bits.
  function automatic logic signed [63:0] qscale(input logic signed [127:0] p);
    logic signed [127:0] t;
    t = p >>> pbre_pkg::CoefFrac;
    return t[63:0];
  endfunction

  assign cfg_ready = (st_r == S_IDLE) && !out_valid_r && !recip_go_r;
  assign in_stall = !((st_r == S_IDLE) && !out_valid_r && !recip_go_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= pbre_pkg::CoefWidth'(64'sd1 <<< pbre_pkg::CoefFrac);
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
      bypass_r <= 1'b1;
      exc_r <= 1'b0;
      harm_r <= '0;
      drive_r <= 20'd32768;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pbre_pkg::RegB0: b0_r <= cfg_data[pbre_pkg::CoefWidth-1:0];
        pbre_pkg::RegB1: b1_r <= cfg_data[pbre_pkg::CoefWidth-1:0];
        pbre_pkg::RegB2: b2_r <= cfg_data[pbre_pkg::CoefWidth-1:0];
        pbre_pkg::RegA1: a1_r <= cfg_data[pbre_pkg::CoefWidth-1:0];
        pbre_pkg::RegA2: a2_r <= cfg_data[pbre_pkg::CoefWidth-1:0];
        pbre_pkg::RegBypass: bypass_r <= cfg_data[0];
        pbre_pkg::RegExcEn: exc_r <= cfg_data[0];
        pbre_pkg::RegHarm: begin
          harm_r <= cfg_data[15:0];
          drive_r <= 20'd32768 + {1'b0, cfg_data[15:0], 3'b000};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    tab_rdata_r <= tab_mem[tab_raddr];
  end

  always_comb begin
    logic signed [63:0] tmp;
    logic [63:0] mag;
    logic [63:0] pos;
    logic signed [63:0] t;
    logic signed [pbre_pkg::SampleWidth+40:0] rnd;
    tmp = '0;
    mag = '0;
    pos = '0;
    t = '0;
    rnd = '0;
    st_nxt = st_r;
    k_nxt = k_r;
    n_nxt = n_r;
    term_nxt = term_r;
    q_nxt = q_r;
    e_nxt = e_r;
    x_nxt = x_r;
    y_nxt = y_r;
    acc_nxt = acc_r;
    lin_nxt = lin_r;
    r_nxt = r_r;
    res_nxt = res_r;
    d1_nxt = d1_r;
    d2_nxt = d2_r;
    neg_nxt = neg_r;
    s_nxt = s_r;
    t0_nxt = t0_r;
    rd_nxt = rd_r;
    recip_nxt = recip_r;
    recip_go_nxt = recip_go_r;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    mreq = '0;
    dstart = 1'b0;
    dnum = '0;
    dden = '0;
    tab_we = 1'b0;
    tab_waddr = k_r;
    tab_wdata = '0;
    tab_raddr = k_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cfg_valid && cfg_ready && cfg_index == pbre_pkg::RegHarm) recip_go_nxt = 1'b1;
    unique case (st_r)
      S_Q: begin
        mreq.start = 1'b1;
        mreq.a = signed'(term_r);
        mreq.b = signed'(ArgA);
        st_nxt = S_QW;
      end
      S_QW: if (!mbusy) begin
        dstart = 1'b1;
        dnum = 64'(mprod >>> 31);
        dden = {60'd0, n_r};
        st_nxt = S_QD;
      end
      S_QD: if (!dbusy) begin
        term_nxt = dquo;
        q_nxt = n_r[0] ? q_r - dquo : q_r + dquo;
        n_nxt = n_r + 4'd1;
        st_nxt = (n_r == 4'd12) ? S_E : S_Q;
        if (n_r == 4'd12) begin
          tab_we = 1'b1;
          tab_waddr = '0;
          tab_wdata = '0;
          k_nxt = 9'd1;
        end
      end
      S_E: begin
        mreq.start = 1'b1;
        mreq.a = signed'(e_r);
        mreq.b = signed'(q_r);
        st_nxt = S_EW;
      end
      S_EW: if (!mbusy) begin
        tmp = 64'((mprod + 128'sd1073741824) >>> 31);
        e_nxt = tmp;
        dstart = 1'b1;
        dnum = (EOne - tmp) << 30;
        dden = EOne + tmp;
        st_nxt = S_TW;
      end
      S_TW: if (!dbusy) begin
        tab_we = 1'b1;
        tab_waddr = k_r;
        tab_wdata = dquo[31:0];
        k_nxt = k_r + 9'd1;
        if (k_r == 9'(pbre_pkg::TanhEntries)) begin
          recip_go_nxt = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_E;
        end
      end
      S_IDLE: begin
        if (recip_go_r) begin
          dstart = 1'b1;
          dnum = 64'd1 << 45;
          dden = {44'd0, drive_r};
          recip_go_nxt = 1'b0;
          st_nxt = S_RW;
        end else if (in_valid && !in_stall) begin
          x_nxt = 64'(in_sample_in) <<< pbre_pkg::InShift;
          if (bypass_r) begin
            lin_nxt = 64'(in_sample_in) <<< pbre_pkg::InShift;
            st_nxt = S_EX;
          end else begin
            st_nxt = S_Y;
          end
        end
      end
      S_RW: if (!dbusy) begin
        recip_nxt = dquo;
        st_nxt = S_IDLE;
      end
      S_Y: begin
        mreq.start = 1'b1;
        mreq.a = 64'(b0_r);
        mreq.b = x_r;
        st_nxt = S_YW;
      end
      S_YW: if (!mbusy) begin
        y_nxt = 64'(pbre_pkg::sat48(qscale(mprod) + 64'(d1_r)));
        st_nxt = S_D1A;
      end
      S_D1A: begin
        mreq.start = 1'b1;
        mreq.a = 64'(b1_r);
        mreq.b = x_r;
        st_nxt = S_D1AW;
      end
      S_D1AW: if (!mbusy) begin
        acc_nxt = qscale(mprod);
        st_nxt = S_D1B;
      end
      S_D1B: begin
        mreq.start = 1'b1;
        mreq.a = 64'(a1_r);
        mreq.b = y_r;
        st_nxt = S_D1BW;
      end
      S_D1BW: if (!mbusy) begin
        d1_nxt = pbre_pkg::sat48(acc_r - qscale(mprod) + 64'(d2_r));
        st_nxt = S_D2A;
      end
      S_D2A: begin
        mreq.start = 1'b1;
        mreq.a = 64'(b2_r);
        mreq.b = x_r;
        st_nxt = S_D2AW;
      end
      S_D2AW: if (!mbusy) begin
        acc_nxt = qscale(mprod);
        st_nxt = S_D2B;
      end
      S_D2B: begin
        mreq.start = 1'b1;
        mreq.a = 64'(a2_r);
        mreq.b = y_r;
        st_nxt = S_D2BW;
      end
      S_D2BW: if (!mbusy) begin
        d2_nxt = pbre_pkg::sat48(acc_r - qscale(mprod));
        lin_nxt = y_r;
        st_nxt = S_EX;
      end
      S_EX: begin
        res_nxt = lin_r;
        if (exc_r && harm_r != '0) begin
          tmp = lin_r - x_r;
          r_nxt = tmp;
          neg_nxt = tmp[63];
          mag = tmp[63] ? 64'd0 - tmp : tmp;
          if (mag > (64'd1 << 41)) mag = 64'd1 << 41;
          mreq.start = 1'b1;
          mreq.a = signed'(mag);
          mreq.b = 64'(drive_r);
          st_nxt = S_SCW;
        end else begin
          st_nxt = S_OUT;
        end
      end
      S_SCW: if (!mbusy) begin
        mag = 64'(mprod >>> 15);
        if (mag > (64'd1 << 41)) mag = 64'd1 << 41;
        s_nxt = mag;
        rd_nxt = 2'd0;
        st_nxt = S_SC;
      end
      S_SC: begin
        // Two table reads: entry idx then idx+1.
        pos = s_r << pbre_pkg::TanhIdxW;
        tab_raddr = (rd_r == 2'd0) ? pos[49:41] : pos[49:41] + 9'd1;
        rd_nxt = rd_r + 2'd1;
        if (rd_r == 2'd1) t0_nxt = tab_rdata_r;
        if (rd_r == 2'd2) st_nxt = S_IP;
      end
      S_IP: begin
        pos = s_r << pbre_pkg::TanhIdxW;
        if (pos[49:41] >= 9'(pbre_pkg::TanhEntries)) begin
          t = 64'sd1 <<< 30;
          acc_nxt = t;
          st_nxt = S_RC;
        end else begin
          mreq.start = 1'b1;
          mreq.a = signed'({32'd0, tab_rdata_r}) - signed'({32'd0, t0_r});
          mreq.b = 64'(pos[40:21]);
          st_nxt = S_IPW;
        end
      end
      S_IPW: if (!mbusy) begin
        acc_nxt = signed'({32'd0, t0_r}) + 64'(mprod >>> 20);
        st_nxt = S_RC;
      end
      S_RC: begin
        mreq.start = 1'b1;
        mreq.a = acc_r;
        mreq.b = signed'(recip_r);
        st_nxt = S_RCW;
      end
      S_RCW: if (!mbusy) begin
        tmp = 64'(mprod >>> 22);
        if (neg_r) tmp = -tmp;
        acc_nxt = 64'(pbre_pkg::sat48(tmp - r_r));
        st_nxt = S_HM;
      end
      S_HM: begin
        mreq.start = 1'b1;
        mreq.a = acc_r;
        mreq.b = 64'(harm_r);
        st_nxt = S_HMW;
      end
      S_HMW: if (!mbusy) begin
        res_nxt = lin_r + 64'(mprod >>> 15);
        st_nxt = S_OUT;
      end
      S_OUT: begin
        rnd = (pbre_pkg::SampleWidth+41)'(res_r) +
              ((pbre_pkg::SampleWidth+41)'(1) <<< (pbre_pkg::InShift - 1));
        rnd = rnd >>> pbre_pkg::InShift;
        if (rnd > (pbre_pkg::SampleWidth+41)'((64'sd1 <<< (pbre_pkg::SampleWidth-1)) - 1))
          out_nxt = {1'b0, {(pbre_pkg::SampleWidth-1){1'b1}}};
        else if (rnd < -((pbre_pkg::SampleWidth+41)'(64'sd1 <<< (pbre_pkg::SampleWidth-1))))
          out_nxt = {1'b1, {(pbre_pkg::SampleWidth-1){1'b0}}};
        else
          out_nxt = rnd[pbre_pkg::SampleWidth-1:0];
        out_valid_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_Q;
      k_r <= '0;
      n_r <= 4'd1;
      term_r <= EOne;
      q_r <= EOne;
      e_r <= EOne;
      d1_r <= '0;
      d2_r <= '0;
      recip_go_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      k_r <= k_nxt;
      n_r <= n_nxt;
      term_r <= term_nxt;
      q_r <= q_nxt;
      e_r <= e_nxt;
      d1_r <= d1_nxt;
      d2_r <= d2_nxt;
      recip_go_r <= recip_go_nxt;
      out_valid_r <= out_valid_nxt;
    end
    recip_r <= recip_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    acc_r <= acc_nxt;
    lin_r <= lin_nxt;
    r_r <= r_nxt;
    res_r <= res_nxt;
    neg_r <= neg_nxt;
    s_r <= s_nxt;
    t0_r <= t0_nxt;
    rd_r <= rd_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_sample_out = out_r;

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sample_out)))
    else $error("result dropped while stalled");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> (st_r == S_IDLE && !out_valid_r)) else $error("config while busy");
`endif

endmodule

// ===== sim/peaking_biquad_residual_exciter_unit_tb.sv =====
`timescale 1ns / 1ps

module peaking_biquad_residual_exciter_unit_tb;

  // Q formats used by the predictor: samples and delays are Q.38 inside a
  // 64-bit signed integer, the tanh table is Q.30 and the drive is Q.15.
  localparam longint Span = longint'(1) <<< 41;
  localparam longint TOne = longint'(1) <<< 30;
  localparam longint EOne = longint'(1) <<< 31;
  localparam longint StHi = (longint'(1) <<< 47) - 1;
  localparam longint StLo = -StHi - 1;
  localparam longint OutHi = (longint'(1) <<< (pbre_pkg::SampleWidth - 1)) - 1;
  localparam longint OutLo = -OutHi - 1;
  localparam int WatchLimit = 150000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [pbre_pkg::SampleWidth-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [pbre_pkg::SampleWidth-1:0] out_sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pbre_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [pbre_pkg::CfgDataW-1:0] cfg_data = '0;

  peaking_biquad_residual_exciter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample_in(in_sample_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_sample_out(out_sample_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be sent and samples that the filter model says must come back.
  logic signed [pbre_pkg::SampleWidth-1:0] pending_samples[$];
  logic signed [pbre_pkg::SampleWidth-1:0] expected_samples[$];

  // Shadow of the block's registers, delay line and derived drive values.
  longint tanh_lut[pbre_pkg::TanhEntries+1];
  longint b0, b1, b2, a1, a2;
  bit bypass_on, exciter_on;
  longint harm, drive, recip;
  longint z1, z2;

  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int watch = 0;
  bit calm = 1'b0;

  // The tanh table is a run of exp(-a) powers turned into (1-e)/(1+e).
  function automatic void build_tanh_lut();
    longint unsigned a, term, e;
    longint q;
    a = (longint'(16) <<< 31) / pbre_pkg::TanhEntries;
    term = EOne;
    e = EOne;
    q = EOne;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * a) >> 31) / n;
      if (n % 2 == 1) q = q - longint'(term);
      else q = q + longint'(term);
    end
    tanh_lut[0] = 0;
    for (int k = 1; k <= pbre_pkg::TanhEntries; k++) begin
      e = (e * longint'(q) + (longint'(1) <<< 30)) >> 31;
      tanh_lut[k] = longint'(((EOne - e) << 30) / (EOne + e));
    end
  endfunction

  function automatic longint clamp48(longint v);
    if (v > StHi) return StHi;
    if (v < StLo) return StLo;
    return v;
  endfunction

  // Coefficient times value, exact in 128 bits, then floored by the fraction width.
  function automatic longint coef_mul(longint c, longint v);
    logic signed [127:0] p;
    p = $signed(c) * $signed(v);
    p = p >>> pbre_pkg::CoefFrac;
    return longint'(p[63:0]);
  endfunction

  // Soft limiter on the residual: tanh(drive*r)/drive in Q.38.
  function automatic longint soft_limit(longint r);
    longint mag, s, pos, idx, f, t, sh;
    mag = (r < 0) ? -r : r;
    if (mag > Span) mag = Span;
    s = (mag * drive) >>> 15;
    if (s > Span) s = Span;
    pos = s * pbre_pkg::TanhEntries;
    idx = pos >>> 41;
    f = (pos & (Span - 1)) >>> 21;
    if (idx >= pbre_pkg::TanhEntries) t = TOne;
    else t = tanh_lut[idx] + (((tanh_lut[idx+1] - tanh_lut[idx]) * f) >>> 20);
    sh = (t * recip) >>> 22;
    return (r < 0) ? -sh : sh;
  endfunction

  function automatic void set_harmonic(longint h);
    harm = h;
    drive = 32768 + 8 * h;
    recip = (longint'(1) <<< 45) / drive;
  endfunction

  function automatic void apply_register(logic [pbre_pkg::CfgIdxW-1:0] idx,
                                         logic [pbre_pkg::CfgDataW-1:0] d);
    case (idx)
      pbre_pkg::RegB0: b0 = longint'($signed(d));
      pbre_pkg::RegB1: b1 = longint'($signed(d));
      pbre_pkg::RegB2: b2 = longint'($signed(d));
      pbre_pkg::RegA1: a1 = longint'($signed(d));
      pbre_pkg::RegA2: a2 = longint'($signed(d));
      pbre_pkg::RegBypass: bypass_on = d[0];
      pbre_pkg::RegExcEn: exciter_on = d[0];
      pbre_pkg::RegHarm: set_harmonic(longint'(d[pbre_pkg::HarmWidth-1:0]));
      default: ;
    endcase
  endfunction

  // One sample through the biquad and the exciter, advancing the delay line.
  function automatic logic signed [pbre_pkg::SampleWidth-1:0] filter_sample(
      logic signed [pbre_pkg::SampleWidth-1:0] smp);
    longint x, y, lin, res, r, d;
    x = longint'(smp) <<< pbre_pkg::InShift;
    if (bypass_on) begin
      lin = x;
    end else begin
      y = clamp48(coef_mul(b0, x) + z1);
      z1 = clamp48(coef_mul(b1, x) - coef_mul(a1, y) + z2);
      z2 = clamp48(coef_mul(b2, x) - coef_mul(a2, y));
      lin = y;
    end
    res = lin;
    if (exciter_on && harm != 0) begin
      r = lin - x;
      d = clamp48(soft_limit(r) - r);
      res = lin + ((d * harm) >>> 15);
    end
    res = (res + (longint'(1) <<< (pbre_pkg::InShift - 1))) >>> pbre_pkg::InShift;
    if (res > OutHi) res = OutHi;
    if (res < OutLo) res = OutLo;
    return res[pbre_pkg::SampleWidth-1:0];
  endfunction

  function automatic logic signed [pbre_pkg::SampleWidth-1:0] pick_sample();
    case ($urandom_range(9))
      0: return {1'b0, {(pbre_pkg::SampleWidth-1){1'b1}}};
      1: return {1'b1, {(pbre_pkg::SampleWidth-1){1'b0}}};
      2: return pbre_pkg::SampleWidth'($signed($urandom_range(2000)) - 1000);
      default: return pbre_pkg::SampleWidth'($urandom());
    endcase
  endfunction

  // Coefficients: mostly within a few units so the filter stays musical,
  // sometimes the full Q4.28 range to drive the delays into saturation.
  function automatic logic [pbre_pkg::CfgDataW-1:0] pick_coef();
    if ($urandom_range(3) == 0) return $urandom();
    return pbre_pkg::CfgDataW'($signed($urandom_range(32'h4000_0000)) - 32'sh2000_0000);
  endfunction

  function automatic logic [pbre_pkg::CfgDataW-1:0] pick_harmonic();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'd32768;
      2: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Driver: a word is taken when valid is high and stall is low at the edge;
  // the next word is presented in the same step, so valid need not drop between
  // back-to-back words; outside the calm phase it is dropped at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_samples.push_back(filter_sample(in_sample_in));
        words_in++;
      end
      if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
        in_valid <= 1'b1;
        in_sample_in <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: every accepted output word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      words_out++;
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected output word, expected none, actual %0d",
                 $realtime, out_sample_out);
        errors++;
      end else begin
        logic signed [pbre_pkg::SampleWidth-1:0] want;
        want = expected_samples.pop_front();
        if (want !== out_sample_out) begin
          $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                   $realtime, want, out_sample_out);
          errors++;
        end
      end
    end
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 16);
  end

  // Watchdog: cycles in which no word moves on any channel. The limit covers
  // the table sweep after reset and the quiet spell before each register write.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      watch <= 0;
    else
      watch <= watch + 1;
    if (watch >= WatchLimit) begin
      $display("%0t: no progress for %0d cycles", $realtime, watch);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_register(logic [pbre_pkg::CfgIdxW-1:0] idx,
                                logic [pbre_pkg::CfgDataW-1:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, d);
    cfg_valid <= 1'b0;
  endtask

  // Let every queued word go through and come back, then let the pipeline
  // settle for longer than its worst latency before touching a register.
  task automatic drain();
    wait (pending_samples.size() == 0 && !in_valid && expected_samples.size() == 0);
    repeat (600) @(posedge clk);
  endtask

  task automatic queue_extremes();
    pending_samples.push_back({1'b0, {(pbre_pkg::SampleWidth-1){1'b1}}});
    pending_samples.push_back({1'b1, {(pbre_pkg::SampleWidth-1){1'b0}}});
    pending_samples.push_back('0);
    pending_samples.push_back(pbre_pkg::SampleWidth'(1));
    pending_samples.push_back('1);
  endtask

  initial begin
    build_tanh_lut();
    b0 = longint'(1) <<< pbre_pkg::CoefFrac;
    b1 = 0; b2 = 0; a1 = 0; a2 = 0;
    bypass_on = 1'b1;
    exciter_on = 1'b0;
    set_harmonic(0);
    z1 = 0; z2 = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Reset defaults first: plain pass-through.
    queue_extremes();
    drain();
    // Bypass with the exciter on at a harmonic of one: the residual
    // is zero, so the output must still equal the input.
    write_register(pbre_pkg::RegExcEn, 32'd1);
    write_register(pbre_pkg::RegHarm, 32'd32768);
    queue_extremes();
    drain();
    // Identity filter, then a heavy boost that saturates the delays and the
    // output, shaped with the largest harmonic value.
    write_register(pbre_pkg::RegBypass, 32'd0);
    write_register(pbre_pkg::RegHarm, 32'h0000_ffff);
    queue_extremes();
    drain();
    write_register(pbre_pkg::RegB0, 32'h7fff_ffff);
    write_register(pbre_pkg::RegB1, 32'h8000_0000);
    write_register(pbre_pkg::RegB2, 32'h7fff_ffff);
    write_register(pbre_pkg::RegA1, 32'h8000_0000);
    write_register(pbre_pkg::RegA2, 32'h7fff_ffff);
    queue_extremes();
    queue_extremes();
    drain();
    // Harmonic zero with the exciter on: linear output only.
    write_register(pbre_pkg::RegHarm, 32'd0);
    queue_extremes();
    drain();

    // Random phases, one register setting each. One phase runs without idling.
    for (int ph = 0; ph < 13; ph++) begin
      write_register(pbre_pkg::RegB0, pick_coef());
      write_register(pbre_pkg::RegB1, pick_coef());
      write_register(pbre_pkg::RegB2, pick_coef());
      write_register(pbre_pkg::RegA1, pick_coef());
      write_register(pbre_pkg::RegA2, pick_coef());
      write_register(pbre_pkg::RegBypass,
                     ($urandom_range(4) == 0) ? 32'hffff_fffe | 32'd1 : 32'd0);
      write_register(pbre_pkg::RegExcEn,
                     ($urandom_range(4) == 0) ? 32'd0 : $urandom() | 32'd1);
      write_register(pbre_pkg::RegHarm, pick_harmonic());
      calm = (ph == 6);
      for (int i = 0; i < 110; i++) pending_samples.push_back(pick_sample());
      drain();
      calm = 1'b0;
    end

    $display("Covered %0d input words and %0d output words over 18 register settings,",
             words_in, words_out);
    $display("including bypass, saturating coefficients and harmonic from zero to full scale.");
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== peaking_biquad_residual_exciter_unit.f =====
rtl/pbre_pkg.sv
rtl/pbre_sermul.sv
rtl/pbre_serdiv.sv
rtl/peaking_biquad_residual_exciter_unit.sv
sim/peaking_biquad_residual_exciter_unit_tb.sv
